[hw/rtl/kst_pkg.sv]
// Package for the keyed set table.
// Holds the operation and status codes and the scan status struct.
// No dependencies.
package kst_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

endpackage

[hw/rtl/keyed_set_table_core.sv]
// Keyed set table: (key, payload) entries kept in slots 0 .. count-1.
// Add/get/remove scan one slot per cycle until the key is found or all count
// slots are checked; on a hit, remove then reads the last entry and moves it
// into the freed slot; pop reads and takes the last entry. One op at a time.
// Reset clears the count and control state; the entry RAM is not cleared.
// Depends on kst_pkg, kst_ram, kst_scan.
module keyed_set_table_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], payload [63:32]
  input  logic [1:0]  s_axis_tuser,   // op [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // key_out [31:0], payload_out [63:32],
                                      // count [70:64], zero [71]
  output logic [2:0]  m_axis_tuser    // status [2:0]
);
  import kst_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned RAM_W = KEY_W + PAY_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_RDLAST = 5'b00100,
    S_TAKE   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] pay_q, pay_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]    slot_q, slot_d;
  status_e          res_status_q, res_status_d;
  logic [KEY_W-1:0] res_key_q, res_key_d;
  logic [PAY_W-1:0] res_pay_q, res_pay_d;

  logic                 m_valid_q, m_valid_d;
  status_e              m_status_q, m_status_d;
  logic [KEY_W-1:0]     m_key_q, m_key_d;
  logic [PAY_W-1:0]     m_pay_q, m_pay_d;
  logic [CNT_OUT_W-1:0] m_cnt_q, m_cnt_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  logic       scan_start, scan_run, scan_rd_en;
  logic [AW-1:0] scan_addr, scan_slot;
  scan_stat_t scan_stat;

  logic [AW-1:0] last_idx;
  logic          out_free;

  assign last_idx = AW'(cnt_q - 1'b1);
  assign out_free = !m_valid_q || m_axis_tready;

  kst_ram #(
    .WIDTH(RAM_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  kst_scan #(
    .CAPACITY(CAPACITY)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .run_i    (scan_run),
    .key_i    (key_q),
    .cnt_i    (cnt_q),
    .rd_key_i (ram_rdata[KEY_W-1:0]),
    .rd_en_o  (scan_rd_en),
    .rd_addr_o(scan_addr),
    .slot_o   (scan_slot),
    .stat_o   (scan_stat)
  );

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    pay_d        = pay_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_pay_d    = res_pay_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_key_d      = m_key_q;
    m_pay_d      = m_pay_q;
    m_cnt_d      = m_cnt_q;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q[AW-1:0];
    ram_wdata    = {pay_q, key_q};
    ram_re       = 1'b0;
    ram_raddr    = scan_addr;
    scan_start   = 1'b0;
    scan_run     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d         = op_e'(s_axis_tuser);
          key_d        = s_axis_tdata[KEY_W-1:0];
          pay_d        = s_axis_tdata[KEY_W+PAY_W-1:KEY_W];
          scan_start   = 1'b1;
          res_status_d = ST_OK;
          res_key_d    = '0;
          res_pay_d    = '0;
          if (op_e'(s_axis_tuser) == OP_POP) begin
            if (cnt_q == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              state_d = S_RDLAST;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        scan_run = 1'b1;
        ram_re   = scan_rd_en;
        if (scan_stat.done) begin
          state_d = S_DONE;
          if (scan_stat.hit) begin
            slot_d = scan_slot;
            case (op_q)
              OP_ADD: begin
                res_status_d = ST_DUP;
              end
              OP_GET: begin
                res_key_d = ram_rdata[KEY_W-1:0];
                res_pay_d = ram_rdata[RAM_W-1:KEY_W];
              end
              OP_REMOVE: begin
                res_key_d = ram_rdata[KEY_W-1:0];
                res_pay_d = ram_rdata[RAM_W-1:KEY_W];
                state_d   = S_RDLAST;
              end
              default: begin
                res_status_d = ST_NOTFOUND;
              end
            endcase
          end else if (op_q == OP_ADD) begin
            if (cnt_q >= CNT_W'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
            end
          end else begin
            res_status_d = ST_NOTFOUND;
          end
        end
      end
      S_RDLAST: begin
        ram_re    = 1'b1;
        ram_raddr = last_idx;
        state_d   = S_TAKE;
      end
      S_TAKE: begin
        cnt_d   = cnt_q - 1'b1;
        state_d = S_DONE;
        if (op_q == OP_POP) begin
          res_key_d = ram_rdata[KEY_W-1:0];
          res_pay_d = ram_rdata[RAM_W-1:KEY_W];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          ram_wdata = ram_rdata;
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_key_d    = res_key_q;
          m_pay_d    = res_pay_q;
          m_cnt_d    = CNT_OUT_W'(cnt_q);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_pay_q    <= res_pay_d;
    m_status_q   <= m_status_d;
    m_key_q      <= m_key_d;
    m_pay_q      <= m_pay_d;
    m_cnt_q      <= m_cnt_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_cnt_q, m_pay_q, m_key_q};
  assign m_axis_tuser  = m_status_q;

endmodule

[hw/rtl/kst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/kst_scan.sv]
// Linear scan unit: walks slots 0 .. count-1, one read issued and one key
// compared per cycle while run_i is high. Depends on kst_pkg.
module kst_scan #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        run_i,
  input  logic [kst_pkg::KEY_W-1:0]   key_i,
  input  logic [$clog2(CAPACITY+1)-1:0] cnt_i,
  input  logic [kst_pkg::KEY_W-1:0]   rd_key_i,
  output logic                        rd_en_o,
  output logic [$clog2(CAPACITY)-1:0] rd_addr_o,
  output logic [$clog2(CAPACITY)-1:0] slot_o,
  output kst_pkg::scan_stat_t         stat_o
);
  import kst_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  logic             hit, miss, issue;

  assign hit   = run_i && pend_q && (rd_key_i == key_i);
  assign miss  = run_i && !pend_q && (idx_q >= cnt_i);
  assign issue = run_i && !hit && (idx_q < cnt_i);

  always_comb begin
    idx_d  = idx_q;
    pend_d = issue;
    pidx_d = idx_q[AW-1:0];
    if (start_i) begin
      idx_d  = '0;
      pend_d = 1'b0;
    end else if (issue) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
  end

  assign rd_en_o     = issue;
  assign rd_addr_o   = idx_q[AW-1:0];
  assign slot_o      = pidx_q;
  assign stat_o.done = hit || miss;
  assign stat_o.hit  = hit;

endmodule
